### rtl/three_joint_arm_inverse_kinematics_assert.svh
// Assertion macros for the arm inverse kinematics block
`ifndef THREE_JOINT_ARM_INVERSE_KINEMATICS_ASSERT_SVH
`define THREE_JOINT_ARM_INVERSE_KINEMATICS_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define TJA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define TJA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/tjaik_pkg.sv
package tjaik_pkg;

    localparam int READING_MAX   = 1023;
    localparam int READING_W     = 10;
    localparam int CORDIC_STEPS  = 20;
    localparam int ANG_W         = 26;
    localparam int ONE_EIGHTY    = 11520;
    localparam int NINETY_FINE   = 5898240;

    // Squared-term widths
    localparam int Q2_W   = 42;
    localparam int P_W    = 23;
    localparam int RAD_W  = 32;
    localparam int VEC_W  = 48;

    // Square root radicand width and side band widths of the two pipelines
    localparam int SQ_IN_W = 2 * RAD_W;
    localparam int SQ_SB_W = 3 + 3*P_W + 14;
    localparam int CD_SB_W = 3 + 3*P_W + 7 + 1;

    // Reciprocal of READING_MAX, scaled by 2^RECIP_SH
    localparam int RECIP_SH = 30;
    localparam longint RECIP = ((64'd1 << RECIP_SH) + READING_MAX - 1) / READING_MAX;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CLAMP = 2'd1,
        ST_XZERO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_L1     = 2'd0,
        REG_L2     = 2'd1,
        REG_OFFSET = 2'd2
    } t_reg_idx;

    function automatic logic [ANG_W-1:0] atan_fine(input int i);
        logic [ANG_W-1:0] v;
        case (i)
            0:  v = 26'd2949120;
            1:  v = 26'd1740967;
            2:  v = 26'd919879;
            3:  v = 26'd466945;
            4:  v = 26'd234379;
            5:  v = 26'd117304;
            6:  v = 26'd58666;
            7:  v = 26'd29335;
            8:  v = 26'd14668;
            9:  v = 26'd7334;
            10: v = 26'd3667;
            11: v = 26'd1833;
            12: v = 26'd917;
            13: v = 26'd458;
            14: v = 26'd229;
            15: v = 26'd115;
            16: v = 26'd57;
            17: v = 26'd29;
            18: v = 26'd14;
            19: v = 26'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/tjaik_if.sv
interface tjaik_if #(parameter int W = 30) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/three_joint_arm_inverse_kinematics.sv
// Three-joint arm inverse kinematics. Each transaction carries three 10-bit position
// readings and yields one result of three joint angles (degrees * 64) and a status.
// Fully pipelined: one transaction is taken every clock cycle while the output is not
// stalled; the path runs through six front arithmetic stages, a 16-stage square root unit,
// a 21-stage CORDIC and the output register. Back-pressure on the output stalls the
// whole pipeline: input ready is high while the output register is empty or the
// output is being accepted, so it follows the output ready combinationally.
// Configuration is taken from a write port and must only be changed while idle.
module three_joint_arm_inverse_kinematics (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    tjaik_if.sink       s_in,
    tjaik_if.source     m_out
);
    import tjaik_pkg::*;
`include "three_joint_arm_inverse_kinematics_assert.svh"

    // Configuration registers
    logic [5:0] r_l1, r_l2;
    logic [7:0] r_off;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= 6'd10; r_l2 <= 6'd10; r_off <= 8'd90;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_L1:     r_l1  <= i_cfg_data[5:0];
                REG_L2:     r_l2  <= i_cfg_data[5:0];
                REG_OFFSET: r_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output stall: pipeline advances when the out register is empty or being accepted
    logic        r_ov;
    logic        en;
    logic [45:0] r_od;
    assign en = !r_ov || m_out.ready;
    assign s_in.ready = en;
    logic in_go;
    assign in_go = s_in.valid && en;

    // Stage 1: reading * reach
    logic        r1_v;
    logic [16:0] r1_m [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= in_go;
        if (en) begin
            for (int k = 0; k < 3; k++)
                r1_m[k] <= 17'(s_in.data[10*k +: 10]) * 17'(7'(r_l1) + 7'(r_l2));
        end
    end

    // Stage 2: divide by READING_MAX through reciprocal
    logic       r2_v;
    logic [6:0] r2_c [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [47:0] pr;
                logic [16:0] qq;
                pr = 48'(r1_m[k]) * 48'(RECIP);
                qq = 17'(pr >> RECIP_SH);
                if (27'(qq) * 27'(READING_MAX) > 27'(r1_m[k])) qq = qq - 17'd1;
                r2_c[k] <= qq[6:0];
            end
        end
    end

    // Stage 3: squares and products
    logic        r3_v;
    logic [6:0]  r3_x, r3_y;
    logic [13:0] r3_xx, r3_yy, r3_zz, r3_l11, r3_l22, r3_l12;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
        if (en) begin
            r3_x <= r2_c[0]; r3_y <= r2_c[1];
            r3_xx <= 14'(r2_c[0]) * 14'(r2_c[0]);
            r3_yy <= 14'(r2_c[1]) * 14'(r2_c[1]);
            r3_zz <= 14'(r2_c[2]) * 14'(r2_c[2]);
            r3_l11 <= 14'(r_l1) * 14'(r_l1);
            r3_l22 <= 14'(r_l2) * 14'(r_l2);
            r3_l12 <= 14'(r_l1) * 14'(r_l2);
        end
    end

    // Stage 4: p terms and q factors
    logic               r4_v;
    logic signed [P_W-1:0] r4_p [3];
    logic [16:0]        r4_s;
    logic [16:0]        r4_qa [3];
    logic [16:0]        r4_qb [3];
    logic [6:0]         r4_x, r4_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= r3_v;
        if (en) begin
            logic [16:0] s;
            s = 17'(r3_xx) + 17'(r3_yy) + 17'(r3_zz);
            r4_s <= s;
            r4_p[0] <= P_W'({r3_xx, 1'b0}) + P_W'(r3_yy);
            r4_p[1] <= P_W'(r3_l11) + P_W'(r3_l22) - P_W'(s);
            r4_p[2] <= P_W'(r3_l11) + P_W'(s) - P_W'(r3_l22);
            r4_qa[0] <= 17'({r3_xx, 2'b0}); r4_qb[0] <= s;
            r4_qa[1] <= 17'({r3_l12, 1'b0}); r4_qb[1] <= 17'({r3_l12, 1'b0});
            r4_qa[2] <= 17'({r3_l11, 2'b0}); r4_qb[2] <= s;
            r4_x <= r3_x; r4_y <= r3_y;
        end
    end

    // Stage 5: q^2 and p^2
    logic               r5_v;
    logic [Q2_W-1:0]    r5_q2 [3];
    logic [Q2_W-1:0]    r5_p2 [3];
    logic signed [P_W-1:0] r5_p [3];
    logic [6:0]         r5_x, r5_y;
    logic [16:0]        r5_s;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en)  r5_v <= r4_v;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic [P_W-1:0] mg;
                mg = r4_p[k] < 0 ? P_W'(-r4_p[k]) : P_W'(r4_p[k]);
                r5_q2[k] <= Q2_W'(r4_qa[k]) * Q2_W'(r4_qb[k]);
                r5_p2[k] <= Q2_W'(mg) * Q2_W'(mg);
                r5_p[k]  <= r4_p[k];
            end
            r5_x <= r4_x; r5_y <= r4_y; r5_s <= r4_s;
        end
    end

    // Stage 6: radicand and clamp decision
    logic               r6_v;
    logic [2*RAD_W-1:0] r6_rad [3];
    logic [2:0]         r6_cl;
    logic signed [P_W-1:0] r6_p [3];
    logic [6:0]         r6_x, r6_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en)  r6_v <= r5_v;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r6_cl[k]  <= r5_p2[k] > r5_q2[k];
                r6_rad[k] <= (2*RAD_W)'(r5_q2[k] - r5_p2[k]) << 16;
                r6_p[k]   <= r5_p[k];
            end
            r6_x <= r5_x; r6_y <= r5_y;
        end
    end

    // Square roots; side band carries clamp, p, x, y
    logic [SQ_SB_W-1:0] sb_in [3];
    logic [SQ_SB_W-1:0] sb_out [3];
    logic [RAD_W-1:0] root [3];
    logic [2:0]      sq_v;
    for (genvar k = 0; k < 3; k++) begin : g_sq
        assign sb_in[k] = {r6_cl, r6_p[0], r6_p[1], r6_p[2], r6_x, r6_y};
        tjaik_isqrt u_sq (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r6_v),
            .i_rad(r6_rad[k]), .i_side(sb_in[k]),
            .o_valid(sq_v[k]), .o_root(root[k]), .o_side(sb_out[k]));
    end

    logic [2:0]            q_cl;
    logic signed [P_W-1:0] q_p [3];
    logic [6:0]            q_x, q_y;
    assign {q_cl, q_p[0], q_p[1], q_p[2], q_x, q_y} = sb_out[0];

    // Four CORDICs: three acos and atan(y/x)
    logic [CD_SB_W-1:0] sb2;
    assign sb2 = {q_cl, q_p[0], q_p[1], q_p[2], q_x, q_x == 7'd0};
    logic [13:0]        ang [4];
    logic [CD_SB_W-1:0] sb2o [4];
    logic [3:0]         cv;
    for (genvar k = 0; k < 4; k++) begin : g_cd
        logic signed [VEC_W-1:0] vx, vy;
        if (k < 3) begin : g_ac
            assign vx = VEC_W'(q_p[k]) <<< 8;
            assign vy = VEC_W'(root[k]);
        end else begin : g_at
            assign vx = VEC_W'({q_x, 8'd0});
            assign vy = VEC_W'({q_y, 8'd0});
        end
        tjaik_cordic u_cd (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sq_v[0]),
            .i_x(vx), .i_y(vy), .i_side(sb2),
            .o_valid(cv[k]), .o_ang(ang[k]), .o_side(sb2o[k]));
    end

    // Final assembly into the output register
    logic [2:0]            f_cl;
    logic signed [P_W-1:0] f_p [3];
    logic [6:0]            f_x;
    logic                  f_xz;
    assign {f_cl, f_p[0], f_p[1], f_p[2], f_x, f_xz} = sb2o[0];

    logic [13:0] a_ac [3];
    logic [45:0] n_od;
    always_comb begin
        logic [14:0] a1;
        logic [13:0] a2;
        logic [14:0] a3;
        for (int k = 0; k < 3; k++)
            a_ac[k] = f_cl[k] ? (f_p[k] > 0 ? 14'd0 : 14'(ONE_EIGHTY)) : ang[k];
        a3 = 15'({r_off, 6'd0}) - 15'(a_ac[0]);
        a2 = 14'(ONE_EIGHTY) - a_ac[1];
        a1 = 15'(a_ac[2]) + 15'(ang[3]);
        if (f_xz)
            n_od = {15'd0, 14'd0, 15'd0, ST_XZERO};
        else
            n_od = {a1, a2, a3, (|f_cl) ? ST_CLAMP : ST_OK};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= cv[0];
        if (en) r_od <= n_od;
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_od;

    `TJA_ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, r_ov && !m_out.ready, !en)
    `TJA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, r_ov && !m_out.ready, $stable(r_od))
    `TJA_ASSERT_IMP(a_xzero_status, i_clk, i_rst_n,
        r_ov && r_od[1:0] == ST_XZERO, r_od[45:2] == 44'd0)
endmodule

### rtl/tjaik_isqrt.sv
// Pipelined integer square root, two result bits per stage, with side payload.
module tjaik_isqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [tjaik_pkg::SQ_IN_W-1:0]     i_rad,
    input  logic [tjaik_pkg::SQ_SB_W-1:0]     i_side,
    output logic                              o_valid,
    output logic [tjaik_pkg::SQ_IN_W/2-1:0]   o_root,
    output logic [tjaik_pkg::SQ_SB_W-1:0]     o_side
);
    import tjaik_pkg::*;
    localparam int IN_W = SQ_IN_W;
    localparam int SB_W = SQ_SB_W;
    localparam int HALF = IN_W / 2;
    localparam int NST  = HALF / 2;

    logic [IN_W-1:0] r_rem  [NST+1];
    logic [IN_W-1:0] r_rad  [NST+1];
    logic [HALF-1:0] r_root [NST+1];
    logic [SB_W-1:0] r_side [NST+1];
    logic            r_vld  [NST+1];

    always_comb begin
        r_rem[0]  = '0;
        r_rad[0]  = i_rad;
        r_root[0] = '0;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    // Each stage resolves two root bits (restoring algorithm)
    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [IN_W-1:0] n_rem;
        logic [HALF-1:0] n_root;
        always_comb begin
            logic [IN_W-1:0] rem;
            logic [HALF-1:0] rt;
            logic [IN_W-1:0] trial;
            rem = r_rem[s];
            rt  = r_root[s];
            for (int k = 0; k < 2; k++) begin
                rem   = {rem[IN_W-3:0],
                         r_rad[s][IN_W-1-2*(2*s+k) -: 2]};
                trial = IN_W'({rt, 2'b01});
                if (rem >= trial) begin
                    rem = rem - trial;
                    rt  = {rt[HALF-2:0], 1'b1};
                end else begin
                    rt  = {rt[HALF-2:0], 1'b0};
                end
            end
            n_rem  = rem;
            n_root = rt;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_rad[s+1]  <= r_rad[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_vld[NST];
    assign o_root  = r_root[NST];
    assign o_side  = r_side[NST];
endmodule

### rtl/tjaik_cordic.sv
// Pipelined vectoring CORDIC giving the angle in degrees * 64, one step per stage.
module tjaik_cordic (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic signed [tjaik_pkg::VEC_W-1:0] i_x,
    input  logic signed [tjaik_pkg::VEC_W-1:0] i_y,
    input  logic [tjaik_pkg::CD_SB_W-1:0]      i_side,
    output logic                        o_valid,
    output logic [13:0]                 o_ang,
    output logic [tjaik_pkg::CD_SB_W-1:0]      o_side
);
    import tjaik_pkg::*;
    localparam int NS = CORDIC_STEPS;
    localparam int W  = VEC_W + 2;

    logic signed [W-1:0]     r_x [NS+1];
    logic signed [W-1:0]     r_y [NS+1];
    logic signed [ANG_W+1:0] r_z [NS+1];
    logic [CD_SB_W-1:0]      r_sb [NS+1];
    logic                    r_v [NS+1];
    logic [13:0]             r_ang;
    logic [CD_SB_W-1:0]      r_oside;
    logic                    r_ov;

    // Pre-rotation for left half-plane
    always_comb begin
        r_v[0]  = i_valid;
        r_sb[0] = i_side;
        if (i_x < 0) begin
            r_x[0] = W'(i_y);
            r_y[0] = -W'(i_x);
            r_z[0] = (ANG_W+2)'(NINETY_FINE);
        end else begin
            r_x[0] = W'(i_x);
            r_y[0] = W'(i_y);
            r_z[0] = '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_it
        logic signed [W-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                r_sb[i+1] <= r_sb[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + (ANG_W+2)'(atan_fine(i));
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - (ANG_W+2)'(atan_fine(i));
                end
            end
        end
    end

    // Round half up to Q.6 and limit to 0..180 degrees
    logic [ANG_W+1:0] zr;
    logic [13:0]      n_ang;
    always_comb begin
        zr = r_z[NS] < 0 ? '0 : (ANG_W+2)'((r_z[NS] + 512) >>> 10);
        n_ang = zr > ONE_EIGHTY ? 14'(ONE_EIGHTY) : zr[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NS];
        end
        if (i_en) begin
            r_ang   <= n_ang;
            r_oside <= r_sb[NS];
        end
    end

    assign o_valid = r_ov;
    assign o_ang   = r_ang;
    assign o_side  = r_oside;
endmodule
